@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file gsp_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define GSP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define GSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/gsp_pkg.sv @@
// ----------------------------------------------------------------------------
// gsp_pkg
// Field widths, command codes and the stored cell word of the grid painter.
// ----------------------------------------------------------------------------
package gsp_pkg;

  localparam int FUNC_W   = 3;
  localparam int COORD_W  = 7;
  localparam int EXT_W    = 8;
  localparam int RAD_W    = 12;
  localparam int MAG_W    = 25;
  localparam int GSIZE_W  = 8;

  // Grid positions, including one past the far edge of a clipped rectangle.
  localparam int POS_W    = 9;
  localparam int SQ_W     = 2 * POS_W;
  // Squared distance in sixteenths: cell distance squared times 256.
  localparam int SUB_BITS = 8;
  localparam int DIST_W   = SQ_W + 1 + SUB_BITS;
  // Half a cell in sixteenths.
  localparam int HALF_CELL = 8;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_POINT = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_RECT  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CIRC  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd4;

  localparam logic [GSIZE_W-1:0] GRID_SIZE_RESET = 8'd128;

  typedef struct packed {
    logic             known;
    logic [MAG_W-1:0] value;
  } cell_word_t;

endpackage

@@ design/gsp_cell_ram.sv @@
// ----------------------------------------------------------------------------
// gsp_cell_ram
// Simple dual-port cell store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gsp_cell_ram
  import gsp_pkg::*;
#(
  parameter int DEPTH  = 16384,
  parameter int ADDR_W = 14
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  cell_word_t        wdata,
  input  logic [ADDR_W-1:0] raddr,
  output cell_word_t        rdata
);

  cell_word_t mem [0:DEPTH-1];
  cell_word_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/grid_shape_painter_top.sv @@
// ----------------------------------------------------------------------------
// grid_shape_painter_top
// Square cell grid painter: clear, point, rectangle, circle and cell read,
// all served from one cell memory with a registered read port.
//
//   channel | dir | handshake            | word
//   in_     | in  | in_valid / in_ready   | one command
//   out_    | out | out_valid / out_ready | one result per command
//   cfg_    | in  | cfg_valid / cfg_ready | grid_size (always ready)
//
// Painting is bound by the single write port: at most one cell written per cycle.
// After reset a sweep over all MAX_GRID*MAX_GRID cells marks every cell
// unknown; in_ready stays low until it ends. A command is accepted while the
// previous result waits in the output register; its own result holds until
// that register frees.
// ----------------------------------------------------------------------------
module grid_shape_painter_top
  import gsp_pkg::*;
#(
  parameter int MAX_GRID = 128
) (
  input  logic                     clk,
  input  logic                     rst_n,

  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [FUNC_W-1:0]        in_func,
  input  logic [COORD_W-1:0]       in_x_coord,
  input  logic [COORD_W-1:0]       in_y_coord,
  input  logic [EXT_W-1:0]         in_rect_length,
  input  logic [EXT_W-1:0]         in_rect_height,
  input  logic [RAD_W-1:0]         in_radius_sixteenths,
  input  logic signed [MAG_W-1:0]  in_magnitude,
  input  logic                     in_filled,

  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [MAG_W-1:0]  out_cell_value,
  output logic                     out_cell_known,
  output logic                     out_rejected,

  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [GSIZE_W-1:0]       cfg_data
);

  localparam int DEPTH  = MAX_GRID * MAX_GRID;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(DEPTH - 1);
  localparam logic [POS_W-1:0]  MAX_POS    = POS_W'(MAX_GRID);

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_CLEAR, ST_READ, ST_RECT, ST_CSETUP, ST_CIRC, ST_DONE
  } state_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [POS_W-1:0] i,
                                                  input logic [POS_W-1:0] j);
    return ADDR_W'(int'(i) * MAX_GRID + int'(j));
  endfunction

  // Control registers
  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   sweep_r, sweep_nxt;
  logic                live_r, live_nxt;
  logic                p1_v_r, p1_v_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [GSIZE_W-1:0]  grid_size_r;

  // Payload registers
  logic [COORD_W-1:0]  x_r, x_nxt;
  logic [COORD_W-1:0]  y_r, y_nxt;
  logic [RAD_W-1:0]    rad_r, rad_nxt;
  cell_word_t          paint_r, paint_nxt;
  logic                fill_r, fill_nxt;
  logic [POS_W-1:0]    i_r, i_nxt, j_r, j_nxt;
  logic [POS_W-1:0]    j_first_r, j_first_nxt;
  logic [POS_W-1:0]    i_last_r, i_last_nxt, j_last_r, j_last_nxt;
  logic [DIST_W-1:0]   outer_r, outer_nxt, inner_r, inner_nxt;
  logic                rad_small_r, rad_small_nxt;
  logic [POS_W-1:0]    p1_i_r, p1_i_nxt, p1_j_r, p1_j_nxt;
  logic [SQ_W-1:0]     p1_sqx_r, p1_sqx_nxt, p1_sqy_r, p1_sqy_nxt;
  logic [MAG_W-1:0]    res_value_r, res_value_nxt;
  logic                res_known_r, res_known_nxt;
  logic                res_rej_r, res_rej_nxt;
  logic [MAG_W-1:0]    out_value_r, out_value_nxt;
  logic                out_known_r, out_known_nxt;
  logic                out_rej_r, out_rej_nxt;

  // Memory ports
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  cell_word_t          mem_wdata;
  logic [ADDR_W-1:0]   mem_raddr;
  cell_word_t          mem_rdata;

  // Datapath helpers
  logic [POS_W-1:0]    n_cur;
  logic                in_fire;
  logic                in_pos_ok;
  logic                row_end, last_cell;
  logic [POS_W-1:0]    i_adv, j_adv;
  logic                rect_in_grid, rect_edge;
  logic [POS_W-1:0]    dx, dy;
  logic [SQ_W:0]       sq_sum;
  logic [DIST_W-1:0]   d2;
  logic                circ_hit;
  logic [RAD_W:0]      rad_p8;
  logic [RAD_W-1:0]    rad_m8;

  gsp_cell_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign n_cur = (POS_W'(grid_size_r) > MAX_POS) ? MAX_POS : POS_W'(grid_size_r);

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign in_pos_ok = (POS_W'(in_x_coord) < n_cur) && (POS_W'(in_y_coord) < n_cur);
  assign mem_raddr = cell_addr(POS_W'(in_x_coord), POS_W'(in_y_coord));

  // Shared raster walk over [i_first..i_last] x [j_first..j_last]
  assign row_end   = (j_r == j_last_r);
  assign last_cell = row_end && (i_r == i_last_r);
  assign j_adv     = row_end ? j_first_r : j_r + POS_W'(1);
  assign i_adv     = row_end ? i_r + POS_W'(1) : i_r;

  assign rect_in_grid = (i_r < n_cur) && (j_r < n_cur);
  assign rect_edge    = (i_r == POS_W'(x_r)) || (i_r == i_last_r) ||
                        (j_r == POS_W'(y_r)) || (j_r == j_last_r);

  assign dx = (i_r >= POS_W'(x_r)) ? i_r - POS_W'(x_r) : POS_W'(x_r) - i_r;
  assign dy = (j_r >= POS_W'(y_r)) ? j_r - POS_W'(y_r) : POS_W'(y_r) - j_r;

  assign sq_sum   = (SQ_W + 1)'(p1_sqx_r) + (SQ_W + 1)'(p1_sqy_r);
  assign d2       = {sq_sum, {SUB_BITS{1'b0}}};
  assign circ_hit = (d2 < outer_r) && (rad_small_r || (d2 > inner_r) || fill_r);

  assign rad_p8 = (RAD_W + 1)'(rad_r) + (RAD_W + 1)'(HALF_CELL);
  assign rad_m8 = rad_r - RAD_W'(HALF_CELL);

  always_comb begin
    state_nxt     = state_r;
    sweep_nxt     = sweep_r;
    live_nxt      = live_r;
    p1_v_nxt      = 1'b0;
    out_valid_nxt = out_valid_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    rad_nxt       = rad_r;
    paint_nxt     = paint_r;
    fill_nxt      = fill_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    j_first_nxt   = j_first_r;
    i_last_nxt    = i_last_r;
    j_last_nxt    = j_last_r;
    outer_nxt     = outer_r;
    inner_nxt     = inner_r;
    rad_small_nxt = rad_small_r;
    p1_i_nxt      = i_r;
    p1_j_nxt      = j_r;
    p1_sqx_nxt    = SQ_W'(dx) * SQ_W'(dx);
    p1_sqy_nxt    = SQ_W'(dy) * SQ_W'(dy);
    res_value_nxt = res_value_r;
    res_known_nxt = res_known_r;
    res_rej_nxt   = res_rej_r;
    out_value_nxt = out_value_r;
    out_known_nxt = out_known_r;
    out_rej_nxt   = out_rej_r;
    mem_we        = 1'b0;
    mem_waddr     = sweep_r;
    mem_wdata     = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_INIT, ST_CLEAR: begin
        mem_we    = 1'b1;
        sweep_nxt = sweep_r + ADDR_W'(1);
        if (sweep_r == SWEEP_LAST) begin
          sweep_nxt = '0;
          state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          x_nxt         = in_x_coord;
          y_nxt         = in_y_coord;
          rad_nxt       = in_radius_sixteenths;
          paint_nxt     = '{known: 1'b1, value: in_magnitude};
          fill_nxt      = in_filled;
          res_value_nxt = '0;
          res_known_nxt = 1'b0;
          res_rej_nxt   = 1'b0;
          case (in_func)
            FUNC_CLEAR: begin
              state_nxt = ST_CLEAR;
            end
            FUNC_POINT: begin
              if (in_pos_ok) begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(POS_W'(in_x_coord), POS_W'(in_y_coord));
                mem_wdata = '{known: 1'b1, value: in_magnitude};
              end else begin
                res_rej_nxt = 1'b1;
              end
              state_nxt = ST_DONE;
            end
            FUNC_RECT: begin
              i_nxt       = POS_W'(in_x_coord);
              j_nxt       = POS_W'(in_y_coord);
              j_first_nxt = POS_W'(in_y_coord);
              i_last_nxt  = POS_W'(in_x_coord) + POS_W'(in_rect_length) - POS_W'(1);
              j_last_nxt  = POS_W'(in_y_coord) + POS_W'(in_rect_height) - POS_W'(1);
              if (in_rect_length == '0 || in_rect_height == '0) begin
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_RECT;
              end
            end
            FUNC_CIRC: begin
              i_nxt       = '0;
              j_nxt       = '0;
              j_first_nxt = '0;
              i_last_nxt  = n_cur - POS_W'(1);
              j_last_nxt  = n_cur - POS_W'(1);
              live_nxt    = 1'b1;
              state_nxt   = (n_cur == '0) ? ST_DONE : ST_CSETUP;
            end
            FUNC_READ: begin
              res_rej_nxt = !in_pos_ok;
              state_nxt   = ST_READ;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_READ: begin
        // read data for the accepted position lands here
        if (!res_rej_r && mem_rdata.known) begin
          res_known_nxt = 1'b1;
          res_value_nxt = mem_rdata.value;
        end
        state_nxt = ST_DONE;
      end
      ST_RECT: begin
        if (rect_in_grid && (rect_edge || fill_r)) begin
          mem_we    = 1'b1;
          mem_waddr = cell_addr(i_r, j_r);
          mem_wdata = paint_r;
        end
        i_nxt = i_adv;
        j_nxt = j_adv;
        if (last_cell) begin
          state_nxt = ST_DONE;
        end
      end
      ST_CSETUP: begin
        outer_nxt     = DIST_W'((2 * (RAD_W + 1))'(rad_p8) * (2 * (RAD_W + 1))'(rad_p8));
        inner_nxt     = DIST_W'((2 * RAD_W)'(rad_m8) * (2 * RAD_W)'(rad_m8));
        rad_small_nxt = (rad_r < RAD_W'(HALF_CELL));
        state_nxt     = ST_CIRC;
      end
      ST_CIRC: begin
        // stage one squares the offsets, stage two tests and writes
        if (live_r) begin
          p1_v_nxt = 1'b1;
          i_nxt    = i_adv;
          j_nxt    = j_adv;
          if (last_cell) begin
            live_nxt = 1'b0;
          end
        end
        if (p1_v_r && circ_hit) begin
          mem_we    = 1'b1;
          mem_waddr = cell_addr(p1_i_r, p1_j_r);
          mem_wdata = paint_r;
        end
        if (!live_r && !p1_v_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold the result until the output register frees
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_value_r;
          out_known_nxt = res_known_r;
          out_rej_nxt   = res_rej_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      sweep_r     <= '0;
      live_r      <= 1'b0;
      p1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_value_r <= '0;
      out_known_r <= 1'b0;
      out_rej_r   <= 1'b0;
      grid_size_r <= GRID_SIZE_RESET;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      live_r      <= live_nxt;
      p1_v_r      <= p1_v_nxt;
      out_valid_r <= out_valid_nxt;
      out_value_r <= out_value_nxt;
      out_known_r <= out_known_nxt;
      out_rej_r   <= out_rej_nxt;
      if (cfg_valid && cfg_ready) begin
        grid_size_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    rad_r       <= rad_nxt;
    paint_r     <= paint_nxt;
    fill_r      <= fill_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    j_first_r   <= j_first_nxt;
    i_last_r    <= i_last_nxt;
    j_last_r    <= j_last_nxt;
    outer_r     <= outer_nxt;
    inner_r     <= inner_nxt;
    rad_small_r <= rad_small_nxt;
    p1_i_r      <= p1_i_nxt;
    p1_j_r      <= p1_j_nxt;
    p1_sqx_r    <= p1_sqx_nxt;
    p1_sqy_r    <= p1_sqy_nxt;
    res_value_r <= res_value_nxt;
    res_known_r <= res_known_nxt;
    res_rej_r   <= res_rej_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_cell_value = out_value_r;
  assign out_cell_known = out_known_r;
  assign out_rejected   = out_rej_r;

endmodule

@@ design/gsp_checker.sv @@
// ----------------------------------------------------------------------------
// gsp_checker
// Port-level checks of the grid painter: result count, result coding,
// output hold under stall and the reset sweep.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gsp_checker
  import gsp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [MAG_W-1:0] out_cell_value,
  input  logic                    out_cell_known,
  input  logic                    out_rejected
);

  // Commands accepted whose result word has not yet been taken
  logic [1:0] outstanding_r;
  logic       in_take, out_take;

  assign in_take  = in_valid && in_ready;
  assign out_take = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outstanding_r <= '0;
    end else if (in_take && !out_take && outstanding_r != 2'd3) begin
      outstanding_r <= outstanding_r + 2'd1;
    end else if (out_take && !in_take && outstanding_r != 2'd0) begin
      outstanding_r <= outstanding_r - 2'd1;
    end
  end

  `GSP_ASSERT_SAME(a_no_spurious_result, clk, rst_n, out_valid, outstanding_r != 2'd0, "result word without a command")
  `GSP_ASSERT_SAME(a_depth_bound, clk, rst_n, 1'b1, outstanding_r <= 2'd2, "more than two commands in flight")
  `GSP_ASSERT_SAME(a_reject_coding, clk, rst_n, out_valid && out_rejected, !out_cell_known && out_cell_value == '0, "rejected word carries data")
  `GSP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_cell_value) && $stable(out_rejected), "stalled result word changed")
  `GSP_ASSERT_SAME(a_reset_sweep, clk, rst_n, !$past(rst_n), !in_ready, "command taken during reset sweep")

endmodule

bind grid_shape_painter_top gsp_checker u_gsp_checker (.*);
